### rtl/mpsp_pkg.sv
// mpsp_pkg: shared types and constants of the markov page successor predictor
`timescale 1ns / 1ps

package mpsp_pkg;

    // fixed field widths
    localparam int PAGE_W     = 10;
    localparam int STATUS_W   = 3;
    localparam int OUT_WGT_W  = 16;
    localparam int PAGES_W    = 11;

    // request kinds
    localparam logic REQ_RECORD  = 1'b0;
    localparam logic REQ_PREDICT = 1'b1;

    // configuration register indexes
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_PAGES  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_NEW     = 3'd0,
        STAT_INC     = 3'd1,
        STAT_REPEAT  = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_PREDICT = 3'd4,
        STAT_REJECT  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_SCAN,
        S_HOLD
    } state_t;

endpackage

### rtl/markov_page_successor_predictor_top.sv
// markov_page_successor_predictor_top: markov successor table with fill and slot memories
`timescale 1ns / 1ps

// First-order Markov table of page transitions. A record word (tuser 0) notes a move from
// the last recorded page to the given page: a new edge gets weight 1 in the next free slot of
// the row, an existing edge is incremented with saturation, a full row drops the edge. A
// predict word (tuser 1) returns the heaviest successor of the page, earliest slot on a tie.
// The row fill counts live in one synchronous memory (NUM_PAGES entries), the slots
// (page and weight) in a second one (NUM_PAGES * SLOTS_PER_PAGE entries), both with a
// registered read. After reset a clearing pass zeroes the fill memory, one row a cycle;
// no input word is taken during it, configuration writes are.
// Flow: a rejected or repeated-page request goes from S_IDLE straight to S_HOLD; any other
// passes S_FILL and, unless the row is empty, S_SCAN over the slots read (up to
// SLOTS_PER_PAGE, a record stops at the matching slot), one slot a cycle through the slot
// memory's single read port. A new word is taken only in S_IDLE. The result sits in an
// output register, so the next word is accepted while a result still waits on m_tready.
module markov_page_successor_predictor_top #(
    parameter int NUM_PAGES      = 1024,
    parameter int SLOTS_PER_PAGE = 4,
    parameter int WEIGHT_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_wdata,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] page, rest zero
    input  logic [0:0]  s_tuser,   // [0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [9:0] predicted_page, [25:10] predicted_weight, rest zero
    output logic [3:0]  m_tuser    // [2:0] status, [3] predicted_valid
);

    localparam int PAGE_W  = mpsp_pkg::PAGE_W;
    localparam int ROW_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int SLOT_AW = $clog2(NUM_PAGES * SLOTS_PER_PAGE);
    localparam int IDX_W   = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
    localparam int FILL_W  = $clog2(SLOTS_PER_PAGE + 1);
    localparam int SLOT_W  = PAGE_W + WEIGHT_BITS;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_PAGES - 1);

    // memories
    logic [FILL_W-1:0] fill_mem [NUM_PAGES];
    logic [SLOT_W-1:0] slot_mem [NUM_PAGES * SLOTS_PER_PAGE];

    // control registers
    mpsp_pkg::state_t            state_reg, state_next;
    logic                        enable_reg, enable_next;
    logic [mpsp_pkg::PAGES_W-1:0] pages_reg, pages_next;
    logic [PAGE_W-1:0]           last_page_reg, last_page_next;
    logic [ROW_W-1:0]            clr_idx_reg, clr_idx_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    // payload registers
    logic                        req_reg, req_next;
    logic [PAGE_W-1:0]           page_reg, page_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [IDX_W-1:0]            scan_idx_reg, scan_idx_next;
    logic                        best_valid_reg, best_valid_next;
    logic [PAGE_W-1:0]           best_pg_reg, best_pg_next;
    logic [WEIGHT_BITS-1:0]      best_w_reg, best_w_next;
    mpsp_pkg::status_t           res_status_reg, res_status_next;
    logic                        res_valid_reg, res_valid_next;
    logic [PAGE_W-1:0]           res_pg_reg, res_pg_next;
    logic [mpsp_pkg::OUT_WGT_W-1:0] res_w_reg, res_w_next;
    logic [31:0]                 m_tdata_reg, m_tdata_next;
    logic [3:0]                  m_tuser_reg, m_tuser_next;

    // memory ports
    logic [FILL_W-1:0]  fill_q_reg;
    logic [ROW_W-1:0]   fill_ra;
    logic               fill_we;
    logic [ROW_W-1:0]   fill_wa;
    logic [FILL_W-1:0]  fill_wd;
    logic [SLOT_W-1:0]  slot_q_reg;
    logic [SLOT_AW-1:0] slot_ra;
    logic [IDX_W-1:0]   slot_rd_idx;
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_wa;
    logic [SLOT_W-1:0]  slot_wd;

    // request decode
    logic              s_accept;
    logic [PAGE_W-1:0] in_page;
    logic              in_rec;
    logic              in_ok;
    logic              in_repeat;
    logic              out_free;

    // scan datapath
    logic [PAGE_W-1:0]      q_pg;
    logic [WEIGHT_BITS-1:0] q_w;
    logic [WEIGHT_BITS-1:0] q_w_inc;
    logic                   scan_match;
    logic                   scan_last;
    logic                   best_upd;
    logic [PAGE_W-1:0]      cand_pg;
    logic [WEIGHT_BITS-1:0] cand_w;
    logic [FILL_W-1:0]      cur_fill;
    logic                   has_room;

    assign s_tready = (state_reg == mpsp_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_page  = s_tdata[PAGE_W-1:0];
    assign in_rec   = (s_tuser[0] == mpsp_pkg::REQ_RECORD);
    // enabled, below pages_in_use and below the table depth
    assign in_ok    = enable_reg && ({1'b0, in_page} < pages_reg)
                      && (17'(in_page) < 17'(NUM_PAGES));
    assign in_repeat = in_rec && (in_page == last_page_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    // record rows come from the last page, predict rows from the given page
    assign row_next = in_rec ? ROW_W'(last_page_reg) : ROW_W'(in_page);
    assign fill_ra  = row_next;

    assign q_pg     = slot_q_reg[WEIGHT_BITS +: PAGE_W];
    assign q_w      = slot_q_reg[0 +: WEIGHT_BITS];
    assign q_w_inc  = (q_w == {WEIGHT_BITS{1'b1}}) ? q_w : q_w + WEIGHT_BITS'(1);
    assign scan_match = (req_reg == mpsp_pkg::REQ_RECORD) && (q_pg == page_reg);
    assign scan_last  = (FILL_W'(scan_idx_reg) + FILL_W'(1)) == fill_reg;
    assign best_upd   = !best_valid_reg || (q_w > best_w_reg);
    assign cand_pg    = best_upd ? q_pg : best_pg_reg;
    assign cand_w     = best_upd ? q_w : best_w_reg;
    assign cur_fill   = (state_reg == mpsp_pkg::S_FILL) ? fill_q_reg : fill_reg;
    assign has_room   = cur_fill < FILL_W'(SLOTS_PER_PAGE);

    // slot read address: slot 0 in the fill cycle, then the slot after the current one
    assign slot_rd_idx = (state_reg == mpsp_pkg::S_FILL) ? '0 : scan_idx_reg + IDX_W'(1);
    assign slot_ra = SLOT_AW'(row_reg) * SLOT_AW'(SLOTS_PER_PAGE) + SLOT_AW'(slot_rd_idx);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpsp_pkg::S_CLEAR: begin
                if (clr_idx_reg == ROW_LAST) begin
                    state_next = mpsp_pkg::S_IDLE;
                end
            end
            mpsp_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (!in_ok || in_repeat) begin
                        state_next = mpsp_pkg::S_HOLD;
                    end else begin
                        state_next = mpsp_pkg::S_FILL;
                    end
                end
            end
            mpsp_pkg::S_FILL: begin
                if (fill_q_reg == '0) begin
                    state_next = mpsp_pkg::S_HOLD;
                end else begin
                    state_next = mpsp_pkg::S_SCAN;
                end
            end
            mpsp_pkg::S_SCAN: begin
                if (scan_match || scan_last) begin
                    state_next = mpsp_pkg::S_HOLD;
                end
            end
            mpsp_pkg::S_HOLD: begin
                if (out_free) begin
                    state_next = mpsp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mpsp_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        enable_next     = enable_reg;
        pages_next      = pages_reg;
        last_page_next  = last_page_reg;
        clr_idx_next    = clr_idx_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        req_next        = req_reg;
        page_next       = page_reg;
        fill_next       = fill_reg;
        scan_idx_next   = scan_idx_reg;
        best_valid_next = best_valid_reg;
        best_pg_next    = best_pg_reg;
        best_w_next     = best_w_reg;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        res_pg_next     = res_pg_reg;
        res_w_next      = res_w_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        fill_we         = 1'b0;
        fill_wa         = row_reg;
        fill_wd         = cur_fill + FILL_W'(1);
        slot_we         = 1'b0;
        slot_wa         = SLOT_AW'(row_reg) * SLOT_AW'(SLOTS_PER_PAGE)
                          + SLOT_AW'(IDX_W'(cur_fill));
        slot_wd         = {page_reg, WEIGHT_BITS'(1)};

        if (cfg_we) begin
            case (cfg_index)
                mpsp_pkg::CFG_ENABLE: enable_next = cfg_wdata[0];
                mpsp_pkg::CFG_PAGES:  pages_next  = cfg_wdata;
                default: begin
                end
            endcase
        end

        case (state_reg)
            mpsp_pkg::S_CLEAR: begin
                fill_we      = 1'b1;
                fill_wa      = clr_idx_reg;
                fill_wd      = '0;
                clr_idx_next = clr_idx_reg + ROW_W'(1);
            end
            mpsp_pkg::S_IDLE: begin
                if (s_accept) begin
                    req_next        = s_tuser[0];
                    page_next       = in_page;
                    res_valid_next  = 1'b0;
                    res_pg_next     = '0;
                    res_w_next      = '0;
                    if (!in_ok) begin
                        res_status_next = mpsp_pkg::STAT_REJECT;
                    end else if (in_repeat) begin
                        res_status_next = mpsp_pkg::STAT_REPEAT;
                    end else if (in_rec) begin
                        last_page_next = in_page;
                    end
                end
            end
            mpsp_pkg::S_FILL: begin
                fill_next       = fill_q_reg;
                scan_idx_next   = '0;
                best_valid_next = 1'b0;
                best_pg_next    = '0;
                best_w_next     = '0;
                if (fill_q_reg == '0) begin
                    // empty row: first edge or no prediction
                    if (req_reg == mpsp_pkg::REQ_RECORD) begin
                        fill_we         = 1'b1;
                        slot_we         = 1'b1;
                        res_status_next = mpsp_pkg::STAT_NEW;
                    end else begin
                        res_status_next = mpsp_pkg::STAT_PREDICT;
                    end
                end
            end
            mpsp_pkg::S_SCAN: begin
                scan_idx_next   = scan_idx_reg + IDX_W'(1);
                best_valid_next = 1'b1;
                best_pg_next    = cand_pg;
                best_w_next     = cand_w;
                if (req_reg == mpsp_pkg::REQ_RECORD) begin
                    if (scan_match) begin
                        slot_we         = 1'b1;
                        slot_wa         = SLOT_AW'(row_reg) * SLOT_AW'(SLOTS_PER_PAGE)
                                          + SLOT_AW'(scan_idx_reg);
                        slot_wd         = {page_reg, q_w_inc};
                        res_status_next = mpsp_pkg::STAT_INC;
                    end else if (scan_last) begin
                        if (has_room) begin
                            fill_we         = 1'b1;
                            slot_we         = 1'b1;
                            res_status_next = mpsp_pkg::STAT_NEW;
                        end else begin
                            res_status_next = mpsp_pkg::STAT_FULL;
                        end
                    end
                end else if (scan_last) begin
                    res_status_next = mpsp_pkg::STAT_PREDICT;
                    res_valid_next  = 1'b1;
                    res_pg_next     = cand_pg;
                    res_w_next      = mpsp_pkg::OUT_WGT_W'(cand_w);
                end
            end
            mpsp_pkg::S_HOLD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = 32'({res_w_reg, res_pg_reg});
                    m_tuser_next  = {res_valid_reg, res_status_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // fill count memory
    always_ff @(posedge aclk) begin
        if (fill_we) begin
            fill_mem[fill_wa] <= fill_wd;
        end
        fill_q_reg <= fill_mem[fill_ra];
    end

    // successor slot memory
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_q_reg <= slot_mem[slot_ra];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mpsp_pkg::S_CLEAR;
            enable_reg    <= 1'b0;
            pages_reg     <= mpsp_pkg::PAGES_W'(1024);
            last_page_reg <= '0;
            clr_idx_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            pages_reg     <= pages_next;
            last_page_reg <= last_page_next;
            clr_idx_reg   <= clr_idx_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        page_reg       <= page_next;
        if (s_accept) begin
            row_reg <= row_next;
        end
        fill_reg       <= fill_next;
        scan_idx_reg   <= scan_idx_next;
        best_valid_reg <= best_valid_next;
        best_pg_reg    <= best_pg_next;
        best_w_reg     <= best_w_next;
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        res_pg_reg     <= res_pg_next;
        res_w_reg      <= res_w_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### sim/tb.sv
// tb: self-checking testbench for the markov page successor predictor
`timescale 1ns / 1ps

module tb;

    localparam int NUM_PAGES      = 1024;
    localparam int SLOTS_PER_PAGE = 4;
    localparam int WEIGHT_BITS    = 16;
    localparam int PAGE_W         = mpsp_pkg::PAGE_W;
    localparam int PAGES_W        = mpsp_pkg::PAGES_W;
    localparam int OUT_WGT_W      = mpsp_pkg::OUT_WGT_W;
    // reset, clearing pass, longest receiver stall, sender gap and scan, several times over
    localparam int IDLE_LIMIT     = 5000;
    localparam int MAX_REPORTS    = 10;
    localparam int POOL_SIZE      = 6;
    localparam int PHASES         = 7;

    // one result word, unpacked into its fields
    typedef struct packed {
        mpsp_pkg::status_t      status;
        logic                   valid;
        logic [PAGE_W-1:0]      page;
        logic [OUT_WGT_W-1:0]   weight;
    } successor_result_t;

    // shadow copy of the transition table and the queue of predicted result words
    class successor_scoreboard;
        logic                 enable;
        logic [PAGES_W-1:0]   pages;
        logic [PAGE_W-1:0]    last_page;
        int unsigned          row_fill [NUM_PAGES];
        logic [PAGE_W-1:0]    succ_page [NUM_PAGES][SLOTS_PER_PAGE];
        longint unsigned      succ_weight [NUM_PAGES][SLOTS_PER_PAGE];
        successor_result_t    expected_results [$];
        int                   mismatches;

        function new();
            enable     = 1'b0;
            pages      = PAGES_W'(1024);
            last_page  = '0;
            mismatches = 0;
            foreach (row_fill[r]) row_fill[r] = 0;
        endfunction

        function void write_register(logic index, logic [PAGES_W-1:0] value);
            if (index == mpsp_pkg::CFG_ENABLE) begin
                enable = value[0];
            end else begin
                pages = value;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // work out the result word that an accepted request word causes
        function void note_request(logic req, logic [PAGE_W-1:0] pg);
            successor_result_t res;
            int unsigned       row;
            int unsigned       fill;
            bit                found;
            longint unsigned   wmax;
            longint unsigned   best;
            wmax       = (64'd1 << WEIGHT_BITS) - 1;
            best       = 0;
            res.status = mpsp_pkg::STAT_REJECT;
            res.valid  = 1'b0;
            res.page   = '0;
            res.weight = '0;
            if (enable && ({1'b0, pg} < pages)) begin
                if (req == mpsp_pkg::REQ_RECORD) begin
                    row = last_page;
                    if (pg == last_page) begin
                        res.status = mpsp_pkg::STAT_REPEAT;
                    end else begin
                        fill       = row_fill[row];
                        found      = 1'b0;
                        res.status = mpsp_pkg::STAT_FULL;
                        for (int i = 0; i < fill && !found; i++) begin
                            if (succ_page[row][i] == pg) begin
                                if (succ_weight[row][i] < wmax) succ_weight[row][i]++;
                                found      = 1'b1;
                                res.status = mpsp_pkg::STAT_INC;
                            end
                        end
                        if (!found && fill < SLOTS_PER_PAGE) begin
                            succ_page[row][fill]   = pg;
                            succ_weight[row][fill] = 1;
                            row_fill[row]          = fill + 1;
                            res.status             = mpsp_pkg::STAT_NEW;
                        end
                        last_page = pg;
                    end
                end else begin
                    res.status = mpsp_pkg::STAT_PREDICT;
                    for (int i = 0; i < row_fill[pg]; i++) begin
                        if (!res.valid || succ_weight[pg][i] > best) begin
                            best      = succ_weight[pg][i];
                            res.page  = succ_page[pg][i];
                            res.valid = 1'b1;
                        end
                    end
                    res.weight = best[OUT_WGT_W-1:0];
                end
            end
            expected_results.push_back(res);
        endfunction

        // fields listed as status, valid, page, weight
        function void check_result(successor_result_t got);
            successor_result_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d valid %0d page %0d weight %0d",
                             got.status, got.valid, got.page, got.weight);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.valid !== want.valid ||
                    got.page !== want.page || got.weight !== want.weight) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.status, want.valid, want.page, want.weight,
                                 got.status, got.valid, got.page, got.weight);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [10:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [9:0] page, rest zero
    logic [0:0]  s_tuser;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // [9:0] predicted_page, [25:10] predicted_weight, rest zero
    logic [3:0]  m_tuser;   // [2:0] status, [3] predicted_valid

    successor_scoreboard sb;
    successor_result_t   seen_result;

    // receiver stall pattern, rotated one bit a cycle
    logic [15:0]         ready_pattern = 16'hffff;
    logic [3:0]          ready_step = 4'd0;
    int                  idle_cycles = 0;

    // working set of pages per phase, so rows fill up and edges get reused
    logic [PAGE_W-1:0]   page_pool [POOL_SIZE];
    int                  cur_pages;
    int                  phase_pages [PHASES];
    logic                phase_enable [PHASES];
    int                  phase_items [PHASES];

    markov_page_successor_predictor_top #(
        .NUM_PAGES      (NUM_PAGES),
        .SLOTS_PER_PAGE (SLOTS_PER_PAGE),
        .WEIGHT_BITS    (WEIGHT_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check every accepted word, then move on along the stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_result.status = mpsp_pkg::status_t'(m_tuser[2:0]);
            seen_result.valid  = m_tuser[3];
            seen_result.page   = m_tdata[9:0];
            seen_result.weight = m_tdata[25:10];
            sb.check_result(seen_result);
        end
        m_tready   <= ready_pattern[ready_step];
        ready_step <= ready_step + 4'd1;
    end

    // watchdog: a stretch longer than IDLE_LIMIT without a handshake on either side ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // present one request word and hold it until the block takes it
    task automatic send_request(input logic req, input logic [PAGE_W-1:0] pg);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, pg};
        s_tuser  <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(req, pg);
    endtask

    // register writes only happen with the block idle
    task automatic set_register(input logic index, input logic [10:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_register(index, value);
        @(posedge aclk);
    endtask

    // stop sending and wait for every outstanding result word
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // random words in bursts; mostly pool pages, some noise over the whole page field
    task automatic send_random(input int count, input int max_gap);
        int                burst_left;
        int                gap;
        logic              req;
        logic [PAGE_W-1:0] pg;
        burst_left = $urandom_range(1, 16);
        for (int i = 0; i < count; i++) begin
            req = ($urandom_range(0, 3) == 0) ? mpsp_pkg::REQ_PREDICT : mpsp_pkg::REQ_RECORD;
            if ($urandom_range(0, 99) < 88) begin
                pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                pg = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
            end
            send_request(req, pg);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    initial begin
        sb        = new();
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= 1'b0;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // table disabled out of reset: both kinds are rejected
        ready_pattern = $urandom | 16'h0001;
        send_request(mpsp_pkg::REQ_RECORD, 10'd3);
        send_request(mpsp_pkg::REQ_PREDICT, 10'd1023);
        drain_results();

        set_register(mpsp_pkg::CFG_ENABLE, 11'd1);
        set_register(mpsp_pkg::CFG_PAGES, 11'd1024);
        // no successors, repeated page, new edges at both page extremes, increment
        send_request(mpsp_pkg::REQ_PREDICT, 10'd0);
        send_request(mpsp_pkg::REQ_RECORD, 10'd0);
        send_request(mpsp_pkg::REQ_RECORD, 10'd1023);
        send_request(mpsp_pkg::REQ_RECORD, 10'd0);
        send_request(mpsp_pkg::REQ_RECORD, 10'd1023);
        send_request(mpsp_pkg::REQ_PREDICT, 10'd0);
        // fill row 10 with four successors, then drop a fifth on a full row
        send_request(mpsp_pkg::REQ_RECORD, 10'd10);
        send_request(mpsp_pkg::REQ_RECORD, 10'd11);
        send_request(mpsp_pkg::REQ_RECORD, 10'd10);
        send_request(mpsp_pkg::REQ_RECORD, 10'd12);
        send_request(mpsp_pkg::REQ_RECORD, 10'd10);
        send_request(mpsp_pkg::REQ_RECORD, 10'd13);
        send_request(mpsp_pkg::REQ_RECORD, 10'd10);
        send_request(mpsp_pkg::REQ_RECORD, 10'd14);
        send_request(mpsp_pkg::REQ_RECORD, 10'd10);
        send_request(mpsp_pkg::REQ_RECORD, 10'd15);
        // equal weights: earliest slot wins
        send_request(mpsp_pkg::REQ_PREDICT, 10'd10);
        send_request(mpsp_pkg::REQ_RECORD, 10'd900);
        drain_results();

        // last page now beyond the tracked range: its row is still written
        set_register(mpsp_pkg::CFG_PAGES, 11'd100);
        send_request(mpsp_pkg::REQ_RECORD, 10'd99);
        send_request(mpsp_pkg::REQ_RECORD, 10'd100);
        send_request(mpsp_pkg::REQ_PREDICT, 10'd900);
        drain_results();

        // smallest range: only page 0
        set_register(mpsp_pkg::CFG_PAGES, 11'd1);
        send_request(mpsp_pkg::REQ_RECORD, 10'd0);
        send_request(mpsp_pkg::REQ_PREDICT, 10'd0);
        drain_results();

        set_register(mpsp_pkg::CFG_PAGES, 11'd1024);
        set_register(mpsp_pkg::CFG_ENABLE, 11'd0);
        send_request(mpsp_pkg::REQ_PREDICT, 10'd900);
        drain_results();
        set_register(mpsp_pkg::CFG_ENABLE, 11'd1);
        send_request(mpsp_pkg::REQ_PREDICT, 10'd900);
        drain_results();

        // weight growth: bounce between two pages at full rate, no stalls
        ready_pattern = 16'hffff;
        send_request(mpsp_pkg::REQ_RECORD, 10'd1000);
        for (int i = 0; i < 8; i++) begin
            send_request(mpsp_pkg::REQ_RECORD, 10'd1001);
            send_request(mpsp_pkg::REQ_RECORD, 10'd1000);
        end
        send_request(mpsp_pkg::REQ_PREDICT, 10'd1000);
        send_request(mpsp_pkg::REQ_PREDICT, 10'd1001);
        drain_results();

        // random phases over several register settings
        phase_pages  = '{1024, 37, 1, 1024, $urandom_range(2, 1023), 1023, 512};
        phase_enable = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        phase_items  = '{175, 175, 175, 40, 175, 175, 175};
        for (int k = 0; k < PHASES; k++) begin
            drain_results();
            set_register(mpsp_pkg::CFG_ENABLE, 11'(phase_enable[k]));
            set_register(mpsp_pkg::CFG_PAGES, 11'(phase_pages[k]));
            cur_pages = phase_pages[k];
            page_pool[0] = PAGE_W'(cur_pages - 1);
            for (int p = 1; p < POOL_SIZE; p++)
                page_pool[p] = PAGE_W'($urandom_range(0, cur_pages - 1));
            // every third phase runs without receiver stalls, another without sender gaps
            ready_pattern = (k % 3 == 0) ? 16'hffff : ($urandom | 16'h0001);
            send_random(phase_items[k], (k % 3 == 1) ? 0 : 8);
        end

        drain_results();
        repeat (16) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
